[src/nea_pkg.sv]
// Shared types and constants of the neighbor exclusion arbiter.
`timescale 1ns / 1ps

package nea_pkg;

    localparam int MAX_SEATS  = 64;
    localparam int SEAT_W     = $clog2(MAX_SEATS);
    localparam int CNT_W      = SEAT_W + 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [CNT_W-1:0] SEAT_COUNT_RESET = CNT_W'(5);

    typedef logic [1:0] t_status;

    localparam t_status ST_THINKING = 2'd0;
    localparam t_status ST_HUNGRY   = 2'd1;
    localparam t_status ST_EATING   = 2'd2;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Command seen by one seat cell in one cycle.
    typedef struct packed {
        logic hit_tgt;
        logic hit_left;
        logic hit_right;
        logic op;
        logic ring_one;
        logic ring_two;
    } t_cell_cmd;

    typedef struct packed {
        logic [SEAT_W-1:0] seat;
        logic              last;
    } t_grant;

endpackage

[src/nea_in_if.sv]
// Request and release channel of the arbiter.
`timescale 1ns / 1ps

interface nea_in_if import nea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [SEAT_W-1:0] seat;

    modport source(output valid, output op, output seat, input ready);
    modport sink(input valid, input op, input seat, output ready);
endinterface

[src/nea_out_if.sv]
// Grant result channel of the arbiter.
`timescale 1ns / 1ps

interface nea_out_if import nea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [SEAT_W-1:0] granted_seat;
    logic              last;

    modport source(output valid, output granted_seat, output last, input ready);
    modport sink(input valid, input granted_seat, input last, output ready);
endinterface

[src/nea_cell.sv]
// One seat cell: holds the seat status and performs its own grant test.
`timescale 1ns / 1ps

module nea_cell import nea_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_status   i_left_st,
    input  t_status   i_right_st,
    output t_status   o_st,
    output logic      o_grant
);

    t_status r_st;
    t_status n_st;

    always_comb begin
        n_st    = r_st;
        o_grant = 1'b0;
        if (i_cmd.hit_tgt) begin
            if (i_cmd.op == OP_REQUEST) begin
                if (i_cmd.ring_one ||
                    (i_left_st != ST_EATING && i_right_st != ST_EATING)) begin
                    n_st    = ST_EATING;
                    o_grant = 1'b1;
                end else begin
                    n_st = ST_HUNGRY;
                end
            end else begin
                n_st = ST_THINKING;
            end
        end else if (i_cmd.hit_left) begin
            // The right neighbor is the releasing seat, which is now thinking.
            if (r_st == ST_HUNGRY && (i_cmd.ring_two || i_left_st != ST_EATING)) begin
                n_st    = ST_EATING;
                o_grant = 1'b1;
            end
        end else if (i_cmd.hit_right) begin
            // The left neighbor is the releasing seat, which is now thinking.
            if (r_st == ST_HUNGRY && (i_cmd.ring_two || i_right_st != ST_EATING)) begin
                n_st    = ST_EATING;
                o_grant = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_THINKING;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

[src/nea_out_fifo.sv]
// Small result queue that takes up to two grants per cycle.
`timescale 1ns / 1ps

module nea_out_fifo import nea_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_cnt,
    input  t_grant                i_data0,
    input  t_grant                i_data1,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_grant                o_data,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_grant                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + FIFO_PTR_W'(1)] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + FIFO_PTR_W'(i_push_cnt);
            r_rp    <= r_rp + FIFO_PTR_W'(w_pop);
            r_count <= r_count + FIFO_CNT_W'(i_push_cnt) - FIFO_CNT_W'(w_pop);
        end
    end

endmodule

[src/neighbour_exclusion_arbiter_core.sv]
// Top level of the neighbor exclusion arbiter: seat cell ring and result queue.
// An accepted item's grants are registered, queued at the end of its second
//   step and shown from the head of the result queue.
// Input pacing: no new item is taken while an item runs its second test step.
// Reset (synchronous, active low) clears all seats to thinking,
//   empties the result queue and sets seat_count to 5.
`timescale 1ns / 1ps

module neighbour_exclusion_arbiter_core import nea_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    nea_in_if.sink           i_req,
    nea_out_if.source        o_grant
);

    // Configuration and ring geometry. A count above the number of cells
    // acts as the full ring.
    logic [CNT_W-1:0]  r_seat_count;
    logic [CNT_W-1:0]  w_n_eff;
    logic [CNT_W-1:0]  w_n_minus1;
    logic [SEAT_W-1:0] w_last_seat;
    logic              w_ring_one;
    logic              w_ring_two;

    assign w_n_eff     = (r_seat_count > CNT_W'(MAX_SEATS)) ? CNT_W'(MAX_SEATS)
                                                            : r_seat_count;
    assign w_n_minus1  = w_n_eff - CNT_W'(1);
    assign w_last_seat = w_n_minus1[SEAT_W-1:0];
    assign w_ring_one  = (w_n_eff == CNT_W'(1));
    assign w_ring_two  = (w_n_eff == CNT_W'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_count <= SEAT_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_seat_count <= i_cfg_wdata;
        end
    end

    // Item sequencing. The first step runs at the accept edge: a request
    // marks and tests its seat, a release clears its seat and tests the left
    // neighbor. The second step, in the following cycle, tests the right neighbor,
    // which can see a grant just made on the left (ring of three).
    logic              r_busy;
    logic              r_rel;
    logic [SEAT_W-1:0] r_right;
    logic              r_ga_valid;
    logic [SEAT_W-1:0] r_ga_seat;

    logic              w_accept;
    logic              w_in_range;
    logic              w_step_a;
    logic [SEAT_W-1:0] w_left_seat;
    logic [SEAT_W-1:0] w_right_seat;

    logic [FIFO_CNT_W-1:0] w_fifo_count;

    // A new item is taken only when no item is in its second step and the queue has room for two more grants.
    assign i_req.ready = !r_busy && (w_fifo_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_range  = (w_n_eff != '0) && ({1'b0, i_req.seat} < w_n_eff);
    assign w_step_a    = w_accept && w_in_range;

    assign w_left_seat  = (i_req.seat == '0) ? w_last_seat : i_req.seat - SEAT_W'(1);
    assign w_right_seat = (i_req.seat == w_last_seat) ? '0 : i_req.seat + SEAT_W'(1);

    // Seat cells. Each cell sees its two ring neighbors; the wrap at the ring
    // ends uses cell zero and the cell that is currently last.
    t_status               w_st      [MAX_SEATS];
    t_status               w_ls      [MAX_SEATS];
    t_status               w_rs      [MAX_SEATS];
    t_cell_cmd             w_cmd     [MAX_SEATS];
    logic [MAX_SEATS-1:0]  w_is_last;
    logic [MAX_SEATS-1:0]  w_grant_vec;
    t_status               w_tail;

    always_comb begin
        w_tail = ST_THINKING;
        for (int k = 0; k < MAX_SEATS; k++) begin
            if (w_is_last[k]) begin
                w_tail = w_tail | w_st[k];
            end
        end
    end

    for (genvar i = 0; i < MAX_SEATS; i++) begin : g_cell
        assign w_is_last[i] = (w_n_eff == CNT_W'(i + 1));

        if (i == 0) begin : g_first
            assign w_ls[i] = w_tail;
        end else begin : g_mid_l
            assign w_ls[i] = w_st[i-1];
        end

        if (i == MAX_SEATS - 1) begin : g_end
            assign w_rs[i] = w_st[0];
        end else begin : g_mid_r
            assign w_rs[i] = w_is_last[i] ? w_st[0] : w_st[i+1];
        end

        assign w_cmd[i].hit_tgt   = w_step_a && (i_req.seat == SEAT_W'(i));
        assign w_cmd[i].hit_left  = w_step_a && (i_req.op == OP_RELEASE) && !w_ring_one &&
                                    (w_left_seat == SEAT_W'(i));
        assign w_cmd[i].hit_right = r_busy && r_rel && (r_right == SEAT_W'(i));
        assign w_cmd[i].op        = i_req.op;
        assign w_cmd[i].ring_one  = w_ring_one;
        assign w_cmd[i].ring_two  = w_ring_two;

        nea_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd[i]),
            .i_left_st  (w_ls[i]),
            .i_right_st (w_rs[i]),
            .o_st       (w_st[i]),
            .o_grant    (w_grant_vec[i])
        );
    end

    logic w_any_grant;
    assign w_any_grant = |w_grant_vec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_rel      <= 1'b0;
            r_ga_valid <= 1'b0;
        end else if (w_accept) begin
            r_busy     <= 1'b1;
            r_rel      <= w_in_range && (i_req.op == OP_RELEASE);
            r_ga_valid <= w_step_a && w_any_grant;
        end else begin
            r_busy     <= 1'b0;
            r_rel      <= 1'b0;
            r_ga_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_right   <= w_right_seat;
            r_ga_seat <= (i_req.op == OP_REQUEST) ? i_req.seat : w_left_seat;
        end
    end

    // Queue the grants of the item at the end of its second step. A first-step
    // grant is last only when the right neighbor was not granted.
    logic       w_gb;
    logic [1:0] w_push_cnt;
    t_grant     w_data0;
    t_grant     w_data1;
    t_grant     w_head;
    logic       w_head_valid;

    assign w_gb       = r_busy && w_any_grant;
    assign w_push_cnt = r_busy ? ({1'b0, r_ga_valid} + {1'b0, w_gb}) : 2'd0;

    always_comb begin
        if (r_ga_valid) begin
            w_data0.seat = r_ga_seat;
            w_data0.last = !w_gb;
        end else begin
            w_data0.seat = r_right;
            w_data0.last = 1'b1;
        end
        w_data1.seat = r_right;
        w_data1.last = 1'b1;
    end

    nea_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_data0    (w_data0),
        .i_data1    (w_data1),
        .i_pop      (o_grant.ready),
        .o_valid    (w_head_valid),
        .o_data     (w_head),
        .o_count    (w_fifo_count)
    );

    assign o_grant.valid        = w_head_valid;
    assign o_grant.granted_seat = w_head.seat;
    assign o_grant.last         = w_head.last;

    // At most one seat cell may grant in any cycle.
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant_vec))
        else $error("more than one seat granted in one cycle");

    // The result queue never overflows.
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // An accepted item holds off the next one for its second step.
    a_two_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_req.ready)
        else $error("item accepted during second step");

endmodule

[tb/sv/neighbour_exclusion_arbiter_core_tb.sv]
// Self-checking testbench of the neighbor exclusion arbiter core.
`timescale 1ns / 1ps

module neighbour_exclusion_arbiter_core_tb;
    import nea_pkg::*;

    // Quiet before a seat count write, hold-off after the last grant, watchdog
    // limit and random part size. Grants come through the result queue after their
    // item is taken; SETTLE_CYCLES of quiet cover an item that grants nothing.
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 34;
    localparam int N_PHASES      = 8;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;
    typedef enum int { SINK_OPEN, SINK_PATTERN, SINK_RANDOM } t_sink_mode;

    // One row of the directed table. Rows that are pinned carry the grants
    // typed in by hand; the others take the grants from the predictor.
    typedef struct packed {
        t_row_kind         kind;
        logic              op;
        logic [SEAT_W-1:0] seat;
        logic [CNT_W-1:0]  ring;
        logic              pinned;
        logic [1:0]        n_res;
        logic [SEAT_W-1:0] g0;
        logic [SEAT_W-1:0] g1;
    } t_row;

    localparam int N_DIR = 26;
    localparam t_row DIR_TAB [N_DIR] = '{
        // Ring of five after reset: a grant, two blocked requests, then a
        // release that frees both neighbors, left one first.
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b1, 2'd1, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd1,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd4,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd0,  7'd0,   1'b1, 2'd2, 6'd4, 6'd1},
        // A request from a seat that already eats is granted again.
        '{ROW_ITEM, OP_REQUEST, 6'd1,  7'd0,   1'b1, 2'd1, 6'd1, 6'd0},
        // A release from a thinking seat still tests its neighbors.
        '{ROW_ITEM, OP_RELEASE, 6'd2,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        // Seats beyond the ring are ignored.
        '{ROW_ITEM, OP_REQUEST, 6'd63, 7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd63, 7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        // An empty ring ignores everything.
        '{ROW_CFG,  OP_REQUEST, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd4,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        // A ring of one: the seat is its own neighbor on both sides.
        '{ROW_CFG,  OP_REQUEST, 6'd0,  7'd1,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b1, 2'd1, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd1,  7'd0,   1'b1, 2'd0, 6'd0, 6'd0},
        // A ring of two: both neighbors are the same seat.
        '{ROW_CFG,  OP_REQUEST, 6'd0,  7'd2,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd1,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        // Full ring, wrapping between the highest seat and seat zero.
        '{ROW_CFG,  OP_REQUEST, 6'd0,  7'd64,  1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd63, 7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        // A seat count above the maximum acts as the full ring.
        '{ROW_CFG,  OP_REQUEST, 6'd0,  7'd127, 1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd62, 7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_RELEASE, 6'd63, 7'd0,   1'b0, 2'd0, 6'd0, 6'd0},
        '{ROW_ITEM, OP_REQUEST, 6'd0,  7'd0,   1'b0, 2'd0, 6'd0, 6'd0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    nea_in_if  req_ch ();
    nea_out_if grant_ch ();

    neighbour_exclusion_arbiter_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_grant     (grant_ch)
    );

    // Predictor state: our own copy of the seat statuses and the seat count.
    t_status           seat_st [MAX_SEATS];
    logic [CNT_W-1:0]  ring_cfg;
    logic [SEAT_W-1:0] grant_seats [2];

    // Grants that are owed by the block, oldest first.
    t_grant grant_q [$];

    int err_cnt;
    int idle_cycles;
    int burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Effective ring size; counts above the maximum act as the full ring.
    function automatic int ring_now();
        return (ring_cfg > MAX_SEATS) ? MAX_SEATS : int'(ring_cfg);
    endfunction

    // Seat s starts eating if it is hungry and neither neighbor eats.
    function automatic bit try_seat(input int s, input int n);
        int l;
        int r;
        l = (s + n - 1) % n;
        r = (s + 1) % n;
        if (seat_st[s] == ST_HUNGRY && seat_st[l] != ST_EATING &&
            seat_st[r] != ST_EATING) begin
            seat_st[s] = ST_EATING;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one item to the seat copy and returns the number of grants,
    // which are left in grant_seats in the order they are emitted.
    function automatic int predict_grants(input logic op, input logic [SEAT_W-1:0] seat);
        int n;
        int s;
        int l;
        int r;
        int cnt;
        n   = ring_now();
        s   = int'(seat);
        cnt = 0;
        if (n == 0 || s >= n) return 0;
        if (op == OP_REQUEST) begin
            seat_st[s] = ST_HUNGRY;
            if (try_seat(s, n)) begin
                grant_seats[cnt] = SEAT_W'(s);
                cnt++;
            end
        end else begin
            l = (s + n - 1) % n;
            r = (s + 1) % n;
            seat_st[s] = ST_THINKING;
            if (try_seat(l, n)) begin
                grant_seats[cnt] = SEAT_W'(l);
                cnt++;
            end
            if (try_seat(r, n)) begin
                grant_seats[cnt] = SEAT_W'(r);
                cnt++;
            end
        end
        return cnt;
    endfunction

    task automatic queue_grants(input int cnt, input logic [SEAT_W-1:0] a,
                                input logic [SEAT_W-1:0] b);
        t_grant g;
        for (int k = 0; k < cnt; k++) begin
            g.seat = (k == 0) ? a : b;
            g.last = (k == cnt - 1);
            grant_q.push_back(g);
        end
    endtask

    // Presents one item and returns at the edge where it is taken. The valid
    // is left high so that the next item of a burst follows without a gap.
    task automatic send_item(input logic op, input logic [SEAT_W-1:0] seat);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.seat  <= seat;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    // Ends a burst now and then with a random gap. Now and then a long burst
    // runs with no gap at all.
    task automatic pace_sender();
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 8);
        end
    endtask

    task automatic accept_and_predict(input logic op, input logic [SEAT_W-1:0] seat);
        int cnt;
        send_item(op, seat);
        cnt = predict_grants(op, seat);
        queue_grants(cnt, grant_seats[0], grant_seats[1]);
    endtask

    // The seat count is written only with the block idle: no item pending,
    // every owed grant received, and a few quiet cycles for items that
    // granted nothing.
    task automatic set_ring(input logic [CNT_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ring_cfg = value;
    endtask

    // The receiver switches between open stretches, a rotating stall pattern
    // and coin-flip stalls.
    initial begin : grant_sink
        t_sink_mode mode;
        int         left;
        int         k;
        logic [7:0] mask;
        grant_ch.ready <= 1'b0;
        mode = SINK_OPEN;
        left = 0;
        k    = 0;
        mask = 8'hff;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_sink_mode'($urandom_range(0, 2));
                left = $urandom_range(16, 96);
                mask = 8'($urandom_range(1, 255));
            end
            left--;
            case (mode)
                SINK_OPEN: begin
                    grant_ch.ready <= 1'b1;
                end
                SINK_PATTERN: begin
                    grant_ch.ready <= mask[k];
                    k = (k + 1) % 8;
                end
                default: begin
                    grant_ch.ready <= 1'($urandom_range(0, 1));
                end
            endcase
        end
    end

    // Grant checker and watchdog. Values are sampled as they stood at the edge.
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (grant_ch.valid && grant_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (grant_ch.valid && grant_ch.ready) begin
                if (grant_q.size() == 0) begin
                    $error("granted_seat: no grant expected, got %0d (last %0b)",
                           grant_ch.granted_seat, grant_ch.last);
                    err_cnt++;
                end else begin
                    exp_g = grant_q.pop_front();
                    if (grant_ch.granted_seat !== exp_g.seat) begin
                        $error("granted_seat: expected %0d, got %0d",
                               exp_g.seat, grant_ch.granted_seat);
                        err_cnt++;
                    end
                    if (grant_ch.last !== exp_g.last) begin
                        $error("last: expected %0b, got %0b", exp_g.last, grant_ch.last);
                        err_cnt++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_row              row;
        int                cnt;
        int                n;
        int                useful;
        int                base;
        logic              op;
        logic [SEAT_W-1:0] seat;
        logic [CNT_W-1:0]  phase_ring [N_PHASES];

        err_cnt     = 0;
        idle_cycles = 0;
        burst_left  = 1;
        foreach (seat_st[i]) seat_st[i] = ST_THINKING;
        ring_cfg = SEAT_COUNT_RESET;

        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_ch.valid <= 1'b0;
        req_ch.op    <= OP_REQUEST;
        req_ch.seat  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_TAB[i];
            if (row.kind == ROW_CFG) begin
                set_ring(row.ring);
            end else begin
                send_item(row.op, row.seat);
                cnt = predict_grants(row.op, row.seat);
                if (row.pinned)
                    queue_grants(int'(row.n_res), row.g0, row.g1);
                else
                    queue_grants(cnt, grant_seats[0], grant_seats[1]);
                pace_sender();
            end
        end

        // Random part: one phase per seat count, extremes included.
        phase_ring = '{7'd2, 7'd64, 7'd3, 7'd127, 7'd1, 7'd6,
                       7'($urandom_range(7, 63)), 7'd5};
        for (int p = 0; p < N_PHASES; p++) begin
            set_ring(phase_ring[p]);
            n      = ring_now();
            base   = $urandom_range(0, 63);
            useful = 0;
            while (useful < PHASE_ITEMS) begin
                // Mostly a cluster of neighboring seats, so that grants
                // contend; the rest lands anywhere, out of range included.
                if ($urandom_range(0, 9) < 6)
                    seat = SEAT_W'((base + $urandom_range(0, 5)) % n);
                else
                    seat = SEAT_W'($urandom_range(0, 63));
                if ($urandom_range(0, 9) == 0) base = $urandom_range(0, 63);

                // Well-behaved seats release after eating and ask otherwise;
                // a quarter of the items pick the operation blindly.
                if ($urandom_range(0, 3) == 0)
                    op = 1'($urandom_range(0, 1));
                else if (int'(seat) < n && seat_st[seat] == ST_EATING)
                    op = OP_RELEASE;
                else
                    op = OP_REQUEST;

                accept_and_predict(op, seat);
                pace_sender();
                if (int'(seat) < n) useful++;
            end
        end

        req_ch.valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
src/nea_pkg.sv
src/nea_in_if.sv
src/nea_out_if.sv
src/nea_cell.sv
src/nea_out_fifo.sv
src/neighbour_exclusion_arbiter_core.sv
tb/sv/neighbour_exclusion_arbiter_core_tb.sv
